/* rtl/lctsf_pkg.sv */
// Shared types, constants and microcode store for the load-cell conditioner.
package lctsf_pkg;

  // Datapath widths
  localparam int RAW_W   = 24;
  localparam int WGT_W   = 25;
  localparam int PCT_W   = 7;
  localparam int SCALE_W = 16;
  localparam int ACC_W   = 32;
  localparam int DIV_W   = 32;
  localparam int ITER_W  = 6;
  localparam int RECIP_W = 32;
  localparam int PROD_W  = 64;

  // Item opcodes
  localparam logic [1:0] OP_FILTERED   = 2'd0;
  localparam logic [1:0] OP_UNFILTERED = 2'd1;
  localparam logic [1:0] OP_TARE       = 2'd2;

  // Configuration register indexes
  localparam logic REG_FILTER_PERCENT = 1'b0;
  localparam logic REG_SCALE_DIVISOR  = 1'b1;

  // Filter weight limit
  localparam logic [PCT_W-1:0]   PCT_MAX    = 7'd100;

  // Quotient bits produced by the scale divide
  localparam logic [ITER_W-1:0] ITER_SCALE   = 6'd25;

  // Fixed divides as (magnitude * RECIP) >> SHIFT, exact over the operand range:
  // below 2^31 for the filter sum, below 2^24 for a tare sample
  localparam int                 HUNDRED_SHIFT = 38;
  localparam int                 AVG_SHIFT     = 28;
  localparam logic [RECIP_W-1:0] HUNDRED_RECIP = 32'd2748779070;

  // Micro-operations driving the datapath
  typedef enum logic [3:0] {
    U_NOP, U_LATCH, U_DIFF, U_DSTART, U_DWAIT, U_MULP, U_MULX,
    U_SAVEF, U_EMIT, U_TARE, U_TACC, U_RMUL, U_RSHIFT
  } uop_t;

  // Divisor source for a divide step
  typedef enum logic [1:0] {
    DS_SCALE, DS_AVG, DS_HUNDRED
  } dsel_t;

  // Sequencer branch conditions
  typedef enum logic [2:0] {
    J_NEXT, J_ALWAYS, J_WAIT_IN, J_DISPATCH, J_DIV, J_OP1, J_FLUSH, J_OUT
  } jcond_t;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    uop_t   uop;
    dsel_t  dsel;
    jcond_t jcond;
    upc_t   target;
  } uword_t;

  // Fixed entry points
  localparam upc_t A_WAIT = 4'd0;
  localparam upc_t A_EMIT = 4'd11;
  localparam upc_t A_TARE = 4'd12;

  // Divider request and response
  typedef struct packed {
    logic                start;
    logic [DIV_W-1:0]    dividend;
    logic [SCALE_W-1:0]  divisor;
    logic [ITER_W-1:0]   iters;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Microprogram store
  function automatic uword_t ucode(input upc_t addr);
    uword_t w;
    case (addr)
      4'd0:  w = '{U_LATCH,  DS_SCALE,   J_WAIT_IN,  A_WAIT};
      4'd1:  w = '{U_NOP,    DS_SCALE,   J_DISPATCH, A_TARE};
      // measurement: offset, scale divide
      4'd2:  w = '{U_DIFF,   DS_SCALE,   J_NEXT,     A_WAIT};
      4'd3:  w = '{U_DSTART, DS_SCALE,   J_NEXT,     A_WAIT};
      4'd4:  w = '{U_DWAIT,  DS_SCALE,   J_DIV,      A_WAIT};
      4'd5:  w = '{U_NOP,    DS_SCALE,   J_OP1,      A_EMIT};
      // smoothing: weighted sum, divide by one hundred
      4'd6:  w = '{U_MULP,   DS_SCALE,   J_NEXT,     A_WAIT};
      4'd7:  w = '{U_MULX,   DS_SCALE,   J_NEXT,     A_WAIT};
      4'd8:  w = '{U_RMUL,   DS_HUNDRED, J_NEXT,     A_WAIT};
      4'd9:  w = '{U_RSHIFT, DS_HUNDRED, J_NEXT,     A_WAIT};
      4'd10: w = '{U_SAVEF,  DS_SCALE,   J_NEXT,     A_WAIT};
      4'd11: w = '{U_EMIT,   DS_SCALE,   J_OUT,      A_WAIT};
      // tare sequence
      4'd12: w = '{U_TARE,   DS_AVG,     J_FLUSH,    A_EMIT};
      4'd13: w = '{U_RMUL,   DS_AVG,     J_NEXT,     A_WAIT};
      4'd14: w = '{U_RSHIFT, DS_AVG,     J_NEXT,     A_WAIT};
      4'd15: w = '{U_TACC,   DS_AVG,     J_ALWAYS,   A_EMIT};
      default: w = '{U_NOP,  DS_SCALE,   J_ALWAYS,   A_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* rtl/load_cell_tare_scale_filter.sv */
// Load-cell conditioner top level: tare averaging, scaling and smoothing.
//
//  channel | direction | handshake              | word
//  in_     | input     | in_valid / in_stall    | op, raw_sample, tare_restart
//  out_    | output    | out_valid / out_stall  | weight_value, tare_done
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word is worked on at a time. The serial scale divider produces 25
// quotient bits at one per cycle, while the fixed divides use a two-step
// reciprocal multiply. Reset (rst_n low, synchronous) clears the tare state,
// filter history and registers to their defaults. A stalled result sits in the
// output register while the next word is taken; the sequencer waits at its emit
// step only while that register holds a stalled result.
module load_cell_tare_scale_filter import lctsf_pkg::*; #(
  parameter int TARE_AVERAGE_COUNT = 4,
  parameter int TARE_FLUSH_COUNT   = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_op,
  input  logic signed [RAW_W-1:0]  in_raw_sample,
  input  logic                     in_tare_restart,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WGT_W-1:0]  out_weight_value,
  output logic                     out_tare_done,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [SCALE_W-1:0]       cfg_data
);

  localparam int SEQ_LEN = TARE_FLUSH_COUNT + TARE_AVERAGE_COUNT;
  localparam int CNT_W   = $clog2(SEQ_LEN + 1);
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(TARE_AVERAGE_COUNT) - 64'd1)
             / 64'(TARE_AVERAGE_COUNT));

  // Sequencer and latched word
  upc_t                      pc_r, pc_nxt;
  logic [1:0]                op_r, op_nxt;
  logic signed [RAW_W-1:0]   raw_r, raw_nxt;
  logic                      restart_r, restart_nxt;

  // Working registers
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [ACC_W-1:0]   prod_r, prod_nxt;
  logic [PROD_W-1:0]         rprod_r, rprod_nxt;
  logic                      neg_r, neg_nxt;
  logic                      tdone_r, tdone_nxt;

  // Persistent state and configuration
  logic signed [RAW_W-1:0]   offset_r, offset_nxt;
  logic signed [RAW_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic signed [WGT_W-1:0]   prev_r, prev_nxt;
  logic [PCT_W-1:0]          pct_r, pct_nxt;
  logic [SCALE_W-1:0]        scale_r, scale_nxt;

  // Output register
  logic                      out_valid_r, out_valid_nxt;
  logic signed [WGT_W-1:0]   out_weight_r, out_weight_nxt;
  logic                      out_done_r, out_done_nxt;

  uword_t                    uw;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;
  logic                      in_fire, out_fire, out_busy, emit_fire;
  logic [PCT_W-1:0]          pct_eff, pct_inv;
  logic [SCALE_W-1:0]        scale_eff;
  logic [ACC_W-1:0]          acc_mag;
  logic signed [ACC_W-1:0]   q_s;
  logic signed [ACC_W:0]     mul_p, mul_x;
  logic [RECIP_W-1:0]        recip_k;
  logic [PROD_W-1:0]         rmul;
  logic [ACC_W-1:0]          rquo;
  logic signed [ACC_W-1:0]   r_s;
  logic [CNT_W-1:0]          count_eff, cnt_inc;
  logic                      in_flush, seq_end, is_meas;
  logic signed [RAW_W-1:0]   sum_new;

  assign uw        = ucode(pc_r);
  assign in_stall  = (pc_r != A_WAIT);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_busy  = out_valid_r && out_stall;
  assign emit_fire = (uw.uop == U_EMIT) && !out_busy;
  assign is_meas   = (op_r == OP_FILTERED) || (op_r == OP_UNFILTERED);

  // Clamp configuration to usable values
  always_comb begin
    pct_eff   = (pct_r > PCT_MAX) ? PCT_MAX : pct_r;
    pct_inv   = PCT_MAX - pct_eff;
    scale_eff = (scale_r == '0) ? SCALE_W'(1) : scale_r;
  end

  // Magnitude, signed quotient and the two filter products
  always_comb begin
    acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    q_s     = neg_r ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);
    mul_p   = prev_r * $signed({1'b0, pct_inv});
    mul_x   = $signed(acc_r[WGT_W-1:0]) * $signed({1'b0, pct_eff});
  end

  // Fixed divides: multiply the magnitude by the reciprocal, then shift and sign
  always_comb begin
    recip_k = (uw.dsel == DS_AVG) ? AVG_RECIP : HUNDRED_RECIP;
    rmul    = PROD_W'(acc_mag) * PROD_W'(recip_k);
    rquo    = (uw.dsel == DS_AVG) ? ACC_W'(rprod_r >> AVG_SHIFT)
                                  : ACC_W'(rprod_r >> HUNDRED_SHIFT);
    r_s     = neg_r ? -$signed(rquo) : $signed(rquo);
  end

  // Tare sequence position
  always_comb begin
    count_eff = restart_r ? '0 : count_r;
    in_flush  = count_eff < CNT_W'(TARE_FLUSH_COUNT);
    cnt_inc   = count_r + 1'b1;
    seq_end   = cnt_inc >= CNT_W'(SEQ_LEN);
    sum_new   = sum_r + acc_r[RAW_W-1:0];
  end

  // Divider request: left-align the magnitude for the scale divide
  always_comb begin
    div_req.start    = (uw.uop == U_DSTART);
    div_req.divisor  = scale_eff;
    div_req.iters    = ITER_SCALE;
    div_req.dividend = acc_mag << (DIV_W - int'(ITER_SCALE));
  end

  lctsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Next step: advance, branch or hold
  always_comb begin
    case (uw.jcond)
      J_NEXT:     pc_nxt = pc_r + 1'b1;
      J_ALWAYS:   pc_nxt = uw.target;
      J_WAIT_IN:  pc_nxt = in_fire ? pc_r + 1'b1 : pc_r;
      J_DISPATCH: begin
        if (op_r == OP_TARE) begin
          pc_nxt = uw.target;
        end else if (is_meas) begin
          pc_nxt = pc_r + 1'b1;
        end else begin
          pc_nxt = A_EMIT;
        end
      end
      J_DIV:      pc_nxt = div_rsp.busy ? pc_r : pc_r + 1'b1;
      J_OP1:      pc_nxt = (op_r == OP_UNFILTERED) ? uw.target : pc_r + 1'b1;
      J_FLUSH:    pc_nxt = in_flush ? uw.target : pc_r + 1'b1;
      J_OUT:      pc_nxt = out_busy ? pc_r : uw.target;
      default:    pc_nxt = A_WAIT;
    endcase
  end

  // Datapath actions of the current control word
  always_comb begin
    op_nxt      = op_r;
    raw_nxt     = raw_r;
    restart_nxt = restart_r;
    acc_nxt     = acc_r;
    prod_nxt    = prod_r;
    rprod_nxt   = rprod_r;
    neg_nxt     = neg_r;
    tdone_nxt   = tdone_r;
    offset_nxt  = offset_r;
    sum_nxt     = sum_r;
    count_nxt   = count_r;
    prev_nxt    = prev_r;
    out_weight_nxt = out_weight_r;
    out_done_nxt   = out_done_r;
    case (uw.uop)
      U_LATCH: begin
        if (in_fire) begin
          op_nxt      = in_op;
          raw_nxt     = in_raw_sample;
          restart_nxt = in_tare_restart;
          acc_nxt     = '0;
          tdone_nxt   = 1'b0;
        end
      end
      U_DIFF: begin
        acc_nxt = {{(ACC_W-RAW_W){raw_r[RAW_W-1]}}, raw_r}
                - {{(ACC_W-RAW_W){offset_r[RAW_W-1]}}, offset_r};
      end
      U_DSTART: neg_nxt = acc_r[ACC_W-1];
      U_DWAIT: begin
        if (!div_rsp.busy) begin
          acc_nxt = q_s;
        end
      end
      U_RMUL: begin
        neg_nxt   = acc_r[ACC_W-1];
        rprod_nxt = rmul;
      end
      U_RSHIFT: acc_nxt = r_s;
      U_MULP:  prod_nxt = ACC_W'(mul_p);
      U_MULX:  acc_nxt  = ACC_W'(mul_x) + prod_r;
      U_SAVEF: prev_nxt = acc_r[WGT_W-1:0];
      U_EMIT: begin
        if (!out_busy) begin
          out_weight_nxt = is_meas ? acc_r[WGT_W-1:0] : '0;
          out_done_nxt   = tdone_r;
        end
      end
      U_TARE: begin
        // restart clears the sequence before this sample counts
        count_nxt = in_flush ? count_eff + 1'b1 : count_eff;
        sum_nxt   = restart_r ? '0 : sum_r;
        acc_nxt   = {{(ACC_W-RAW_W){raw_r[RAW_W-1]}}, raw_r};
      end
      U_TACC: begin
        if (seq_end) begin
          offset_nxt = sum_new;
          tdone_nxt  = 1'b1;
          count_nxt  = '0;
          sum_nxt    = '0;
        end else begin
          count_nxt = cnt_inc;
          sum_nxt   = sum_new;
        end
      end
      default: ;
    endcase
  end

  // Output valid: set on emit, drop when taken
  always_comb begin
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Configuration writes
  always_comb begin
    pct_nxt   = pct_r;
    scale_nxt = scale_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FILTER_PERCENT: pct_nxt   = cfg_data[PCT_W-1:0];
        REG_SCALE_DIVISOR:  scale_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= A_WAIT;
      tdone_r     <= 1'b0;
      offset_r    <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      prev_r      <= '0;
      pct_r       <= PCT_W'(10);
      scale_r     <= SCALE_W'(719);
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      tdone_r     <= tdone_nxt;
      offset_r    <= offset_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      prev_r      <= prev_nxt;
      pct_r       <= pct_nxt;
      scale_r     <= scale_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    raw_r        <= raw_nxt;
    restart_r    <= restart_nxt;
    acc_r        <= acc_nxt;
    prod_r       <= prod_nxt;
    rprod_r      <= rprod_nxt;
    neg_r        <= neg_nxt;
    out_weight_r <= out_weight_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_weight_value = out_weight_r;
  assign out_tare_done    = out_done_r;

  // Divider runs only while the sequencer waits on it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> uw.uop == U_DWAIT)
    else $error("divider busy outside a wait step");

  // A result appears only from the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(uw.uop) == U_EMIT)
    else $error("result raised outside emit step");

  // Tare position stays inside the sequence
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CNT_W'(SEQ_LEN))
    else $error("tare count past sequence end");

  // A completed tare carries a zero weight
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_weight_r == '0)
    else $error("tare result with nonzero weight");

endmodule

/* rtl/lctsf_div.sv */
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
module lctsf_div import lctsf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                busy_r, busy_nxt;
  logic [ITER_W-1:0]   cnt_r, cnt_nxt;
  logic [DIV_W-1:0]    quo_r, quo_nxt;
  logic [SCALE_W-1:0]  rem_r, rem_nxt;
  logic [SCALE_W-1:0]  dvs_r, dvs_nxt;
  logic [SCALE_W:0]    rem_sh;
  logic [SCALE_W+1:0]  diff;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
  end

  // Load on start, then shift one bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.iters;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (diff[SCALE_W+1]) begin
        rem_nxt = rem_sh[SCALE_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[SCALE_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.quotient = quo_r;

  // A running divide always has bits left to produce
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("divider busy with no bits left");

  // Busy only starts from a start request
  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(req.start))
    else $error("divider started without request");

endmodule

/* dv/load_cell_tare_scale_filter_tb.sv */
// Self-checking testbench for the load-cell tare, scale and smoothing conditioner.
module load_cell_tare_scale_filter_tb;
  import lctsf_pkg::*;

  localparam logic [1:0] OP_RESERVED  = 2'd3;
  localparam int TARE_FLUSH_LEN       = 5;
  localparam int TARE_AVG_LEN         = 4;
  localparam int RESET_CYCLES         = 12;
  localparam int HOLD_CYCLES          = 300;
  localparam int DRAIN_CYCLES         = 100;
  localparam int QUIET_LIMIT          = 3000;
  localparam int RAW_MAX              = 8388607;
  localparam int RAW_MIN              = -8388608;

  typedef struct {
    logic [1:0]              op;
    logic signed [RAW_W-1:0] raw;
    logic                    restart;
  } sample_t;

  typedef struct {
    logic signed [WGT_W-1:0] weight;
    logic                    done;
  } reading_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_op = '0;
  logic signed [RAW_W-1:0] in_raw_sample = '0;
  logic                    in_tare_restart = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [WGT_W-1:0] out_weight_value;
  logic                    out_tare_done;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_index = REG_FILTER_PERCENT;
  logic [SCALE_W-1:0]      cfg_data = '0;

  load_cell_tare_scale_filter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_raw_sample    (in_raw_sample),
    .in_tare_restart  (in_tare_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_weight_value (out_weight_value),
    .out_tare_done    (out_tare_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  // Predictor state and register shadows
  longint      tare_ofs = 0;
  longint      tare_acc = 0;
  int unsigned tare_pos = 0;
  longint      smooth_prev = 0;
  int unsigned pct_reg = 10;
  int unsigned scale_reg = 719;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];

  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_gap_max = 7;
  int unsigned rx_gap_max = 7;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;
  int unsigned errors = 0;
  int unsigned words_in = 0;
  int unsigned words_checked = 0;
  int unsigned tares_done = 0;
  int unsigned settings_used = 1;
  sample_t     drive_word;

  function automatic longint scaled_reading(input logic signed [RAW_W-1:0] raw);
    longint divisor;
    divisor = (scale_reg == 0) ? 1 : longint'(scale_reg);
    return (longint'(raw) - tare_ofs) / divisor;
  endfunction

  // Advance the conditioner model by one word and return its result
  function automatic reading_t condition_sample(input sample_t s);
    reading_t r;
    longint   x;
    longint   p;
    r.weight = '0;
    r.done   = 1'b0;
    case (s.op)
      OP_TARE: begin
        if (s.restart) begin
          tare_pos = 0;
          tare_acc = 0;
        end
        if (tare_pos < TARE_FLUSH_LEN) begin
          tare_pos++;
        end else begin
          tare_acc += longint'(s.raw) / TARE_AVG_LEN;
          tare_pos++;
          if (tare_pos >= TARE_FLUSH_LEN + TARE_AVG_LEN) begin
            tare_ofs = tare_acc;
            r.done   = 1'b1;
            tare_pos = 0;
            tare_acc = 0;
          end
        end
      end
      OP_UNFILTERED: begin
        r.weight = WGT_W'(scaled_reading(s.raw));
      end
      OP_FILTERED: begin
        x = scaled_reading(s.raw);
        p = (pct_reg > PCT_MAX) ? longint'(PCT_MAX) : longint'(pct_reg);
        smooth_prev = (smooth_prev * (100 - p) + x * p) / 100;
        r.weight = WGT_W'(smooth_prev);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Sample handshakes, predict accepted words, check results
  always @(posedge clk) begin
    sample_t  s;
    reading_t e;
    in_fire  = in_valid && !in_stall;
    out_fire = out_valid && !out_stall;
    if (in_fire) begin
      s.op      = in_op;
      s.raw     = in_raw_sample;
      s.restart = in_tare_restart;
      expected_readings.push_back(condition_sample(s));
      words_in++;
    end
    if (out_fire) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected word: weight_value %0d tare_done %0b",
               out_weight_value, out_tare_done);
        errors++;
      end else begin
        e = expected_readings.pop_front();
        if (out_weight_value !== e.weight) begin
          $error("weight_value: expected %0d, actual %0d", e.weight, out_weight_value);
          errors++;
        end
        if (out_tare_done !== e.done) begin
          $error("tare_done: expected %0b, actual %0b", e.done, out_tare_done);
          errors++;
        end
        if (e.done) tares_done++;
        words_checked++;
      end
    end
    if (in_fire || out_fire || (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else if (rst_n) quiet_cycles++;
  end

  // Drive input words from the pending queue with random gaps
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        drive_word = pending_samples.pop_front();
        in_op           <= drive_word.op;
        in_raw_sample   <= drive_word.raw;
        in_tare_restart <= drive_word.restart;
        in_valid        <= 1'b1;
        tx_wait = $urandom_range(0, tx_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel: random per word, plus one long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (out_fire) rx_wait = $urandom_range(0, rx_gap_max);
      if (out_valid && rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("FAIL");
    $finish;
  end

  task automatic queue_sample(input logic [1:0] op, input int raw, input logic restart);
    sample_t s;
    s.op      = op;
    s.raw     = raw[RAW_W-1:0];
    s.restart = restart;
    pending_samples.push_back(s);
  endtask

  function automatic int rand_raw();
    int unsigned v;
    case ($urandom_range(0, 7))
      0: return RAW_MAX;
      1: return RAW_MIN;
      2: return int'($urandom_range(0, 2000)) - 1000;
      default: begin
        v = $urandom();
        return int'({{8{v[RAW_W-1]}}, v[RAW_W-1:0]});
      end
    endcase
  endfunction

  // Queue a well-formed mix: full tare runs among measurements and noise
  task automatic fill_random(input int unsigned n);
    int unsigned pushed;
    int unsigned pick;
    pushed = 0;
    while (pushed < n) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_sample(OP_TARE, rand_raw(), 1'b1);
        for (int i = 1; i < TARE_FLUSH_LEN + TARE_AVG_LEN; i++)
          queue_sample(OP_TARE, rand_raw(), 1'b0);
        pushed += TARE_FLUSH_LEN + TARE_AVG_LEN;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40)
          queue_sample(OP_FILTERED, rand_raw(), 1'($urandom_range(0, 1)));
        else if (pick < 65)
          queue_sample(OP_UNFILTERED, rand_raw(), 1'($urandom_range(0, 1)));
        else if (pick < 70)
          queue_sample(OP_RESERVED, rand_raw(), 1'($urandom_range(0, 1)));
        else
          queue_sample(OP_TARE, rand_raw(), 1'($urandom_range(0, 15) == 0));
        pushed++;
      end
    end
  endtask

  // Wait until every word is sent and every result has come back
  task automatic drain();
    while (pending_samples.size() != 0 || in_valid || expected_readings.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [SCALE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_FILTER_PERCENT) pct_reg = data[PCT_W-1:0];
    else scale_reg = data;
  endtask

  task automatic apply_settings(input logic [SCALE_W-1:0] pct, input logic [SCALE_W-1:0] scale);
    write_reg(REG_FILTER_PERCENT, pct);
    write_reg(REG_SCALE_DIVISOR, scale);
    settings_used++;
  endtask

  initial begin
    logic [SCALE_W-1:0] pct;
    logic [SCALE_W-1:0] scale;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words at reset settings: field extremes and every op
    queue_sample(OP_UNFILTERED, RAW_MAX, 1'b0);
    queue_sample(OP_UNFILTERED, RAW_MIN, 1'b0);
    queue_sample(OP_FILTERED, RAW_MAX, 1'b0);
    queue_sample(OP_FILTERED, RAW_MIN, 1'b0);
    queue_sample(OP_RESERVED, RAW_MAX, 1'b1);
    queue_sample(OP_UNFILTERED, -1, 1'b1);
    queue_sample(OP_FILTERED, 0, 1'b1);
    // Full tare sequence, averaging values that truncate toward zero
    queue_sample(OP_TARE, 123, 1'b1);
    for (int i = 1; i < TARE_FLUSH_LEN; i++) queue_sample(OP_TARE, RAW_MAX, 1'b0);
    queue_sample(OP_TARE, RAW_MIN, 1'b0);
    queue_sample(OP_TARE, -5, 1'b0);
    queue_sample(OP_TARE, 7, 1'b0);
    queue_sample(OP_TARE, RAW_MAX, 1'b0);
    // Measure against the new offset, then restart a sequence midway
    queue_sample(OP_UNFILTERED, RAW_MAX, 1'b0);
    queue_sample(OP_TARE, 1000, 1'b0);
    queue_sample(OP_TARE, 2000, 1'b0);
    queue_sample(OP_TARE, -3000, 1'b1);
    queue_sample(OP_FILTERED, RAW_MIN, 1'b0);
    queue_sample(OP_UNFILTERED, 0, 1'b0);
    drain();

    // Corner settings: no weight, full weight, above full with zero divisor, half weight over 3
    for (int c = 0; c < 4; c++) begin
      case (c)
        0: apply_settings(16'd0, 16'd1);
        1: apply_settings(16'd100, 16'hFFFF);
        2: apply_settings(16'hFFFF, 16'd0);
        default: apply_settings(16'd50, 16'd3);
      endcase
      fill_random(40);
      drain();
    end

    // Random settings; the first phase holds off the receiver to back up the block
    for (int r = 0; r < 12; r++) begin
      case ($urandom_range(0, 3))
        0: pct = 16'(PCT_MAX);
        1: pct = 16'($urandom_range(0, 65535));
        default: pct = 16'($urandom_range(0, 100));
      endcase
      case ($urandom_range(0, 7))
        0: scale = '0;
        1, 2: scale = 16'($urandom_range(1, 32));
        default: scale = 16'($urandom_range(0, 65535));
      endcase
      apply_settings(pct, scale);
      tx_gap_max = (r % 2 == 1) ? 0 : 7;
      rx_gap_max = (r % 2 == 1) ? 0 : 7;
      if (r == 0) begin
        tx_gap_max = 0;
        hold_req   = 1'b1;
      end
      fill_random(110);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_readings.size() != 0) begin
      $error("%0d expected words never arrived", expected_readings.size());
      errors++;
    end
    $display("Sent %0d samples over %0d register settings, %0d tare offsets completed.",
             words_in, settings_used, tares_done);
    $display("Checked %0d result words with random gaps, a long output hold-off and drains.",
             words_checked);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
